// ===== src/f2i_pkg.sv =====
// Package for the float-to-integer converter: format, size and rounding codes
// and the stage payload types. Depends on nothing.
package f2i_pkg;

  localparam logic [1:0] FMT_HALF   = 2'd0;
  localparam logic [1:0] FMT_SINGLE = 2'd1;

  localparam logic [1:0] SIZE_8  = 2'd0;
  localparam logic [1:0] SIZE_16 = 2'd1;
  localparam logic [1:0] SIZE_32 = 2'd2;
  localparam logic [1:0] SIZE_64 = 2'd3;

  localparam logic [2:0] RM_RNE = 3'd0;
  localparam logic [2:0] RM_RDN = 3'd2;
  localparam logic [2:0] RM_RUP = 3'd3;
  localparam logic [2:0] RM_RMM = 3'd4;

  // Stage one to two: unpacked operand.
  typedef struct packed {
    logic        sign;
    logic        nan;
    logic        big;
    logic [52:0] mant;
    logic        left;      // shift is left (shift >= 0)
    logic [11:0] amt;       // shift magnitude
    logic [1:0]  size;
    logic        sgn;
    logic        sat;
    logic [2:0]  rm;
  } unpack_t;

  // Stage two to three: integer part with rounding bits.
  typedef struct packed {
    logic        sign;
    logic        nan;
    logic        big;
    logic [63:0] ip;
    logic        hbit;
    logic        sticky;
    logic [1:0]  size;
    logic        sgn;
    logic        sat;
    logic [2:0]  rm;
  } shift_t;

  // Stage three to four: rounded magnitude.
  typedef struct packed {
    logic        sign;
    logic        nan;
    logic        big;
    logic [63:0] mag;
    logic [1:0]  size;
    logic        sgn;
    logic        sat;
  } round_t;

endpackage

// ===== src/float_to_int_convert.sv =====
// Top level of the float-to-integer converter: a four-stage pipeline.
// Depends on f2i_pkg for codes and stage payload types.
//
// Usage: drive the operand fields and raise start_i. busy_o is always low, so
// a beat is accepted at every clock edge where start_i is high, one per cycle.
// Stage one unpacks the float, stage two aligns the mantissa with a barrel
// shift and gathers the guard and sticky bits, stage three rounds with one
// 64-bit increment, stage four clamps or wraps into the destination and
// extends narrow results. The four register stages s1_q, s2_q, s3_q and res_q
// load in that order, the first at the accepting edge, and the result is on
// result_bits_o with done_o high, for one cycle only. Throughput is one
// conversion per cycle. The receiver cannot stall the result, and nothing is
// ever held back. Reset clears all stage valid bits, so no result comes out
// until new beats enter; payload registers are not reset.
module float_to_int_convert (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [63:0] source_bits_i,
  input  logic [1:0]  source_format_i,
  input  logic [1:0]  dest_size_i,
  input  logic        dest_signed_i,
  input  logic        saturate_i,
  input  logic [2:0]  round_mode_i,
  output logic        done_o,
  output logic [63:0] result_bits_o
);

  f2i_pkg::unpack_t s1_d, s1_q;
  f2i_pkg::shift_t  s2_d, s2_q;
  f2i_pkg::round_t  s3_d, s3_q;
  logic [63:0]      res_d, res_q;
  logic [3:0]       vld_q;

  assign busy_o = 1'b0;

  // Stage one: field extraction and shift amount.
  always_comb begin
    logic [10:0] ef, emx;
    logic [51:0] fr;
    logic        sg;
    logic [12:0] e, bias_m;
    logic [13:0] sh;
    emx = 11'h7ff;
    case (source_format_i)
      f2i_pkg::FMT_HALF: begin
        ef = {6'd0, source_bits_i[14:10]};
        fr = {42'd0, source_bits_i[9:0]};
        sg = source_bits_i[15];
        emx = 11'h1f;
        bias_m = 13'd25;
      end
      f2i_pkg::FMT_SINGLE: begin
        ef = {3'd0, source_bits_i[30:23]};
        fr = {29'd0, source_bits_i[22:0]};
        sg = source_bits_i[31];
        emx = 11'hff;
        bias_m = 13'd150;
      end
      default: begin
        ef = source_bits_i[62:52];
        fr = source_bits_i[51:0];
        sg = source_bits_i[63];
        bias_m = 13'd1075;
      end
    endcase
    e = (ef != 11'd0) ? {2'd0, ef} : 13'd1;
    sh = {1'b0, e} - {1'b0, bias_m};
    s1_d.sign = sg;
    s1_d.nan  = (ef == emx) && (fr != 52'd0);
    s1_d.big  = (ef == emx) && (fr == 52'd0);
    case (source_format_i)
      f2i_pkg::FMT_HALF:   s1_d.mant = {42'd0, ef != 11'd0, fr[9:0]};
      f2i_pkg::FMT_SINGLE: s1_d.mant = {29'd0, ef != 11'd0, fr[22:0]};
      default:             s1_d.mant = {ef != 11'd0, fr};
    endcase
    s1_d.left = !sh[13];
    s1_d.amt  = sh[13] ? 12'(-sh) : sh[11:0];
    s1_d.size = dest_size_i;
    s1_d.sgn  = dest_signed_i;
    s1_d.sat  = saturate_i;
    s1_d.rm   = round_mode_i;
  end

  // Stage two: alignment.
  always_comb begin
    logic [116:0] wide;
    logic [63:0]  ext;
    s2_d.sign = s1_q.sign;
    s2_d.nan  = s1_q.nan;
    s2_d.big  = s1_q.big;
    s2_d.size = s1_q.size;
    s2_d.sgn  = s1_q.sgn;
    s2_d.sat  = s1_q.sat;
    s2_d.rm   = s1_q.rm;
    s2_d.hbit = 1'b0;
    s2_d.sticky = 1'b0;
    s2_d.ip   = '0;
    ext = {11'd0, s1_q.mant};
    wide = '0;
    if (s1_q.nan || s1_q.big) begin
      s2_d.ip = '0;
    end else if (s1_q.left) begin
      if (s1_q.amt >= 12'd64) begin
        s2_d.big = (s1_q.mant != 53'd0);
      end else begin
        wide = {53'd0, ext} << s1_q.amt[5:0];
        s2_d.big = (wide[116:64] != 53'd0);
        s2_d.ip  = wide[63:0];
      end
    end else if (s1_q.amt >= 12'd64) begin
      s2_d.sticky = (s1_q.mant != 53'd0);
    end else begin
      // Place the mantissa above 64 fraction bits, then shift right.
      wide = {ext[52:0], 64'd0} >> s1_q.amt[5:0];
      s2_d.ip     = {11'd0, wide[116:64]};
      s2_d.hbit   = wide[63];
      s2_d.sticky = (wide[62:0] != 63'd0);
    end
  end

  // Stage three: rounding increment.
  always_comb begin
    logic inc;
    case (s2_q.rm)
      f2i_pkg::RM_RNE: inc = s2_q.hbit && (s2_q.sticky || s2_q.ip[0]);
      f2i_pkg::RM_RDN: inc = s2_q.sign && (s2_q.hbit || s2_q.sticky);
      f2i_pkg::RM_RUP: inc = !s2_q.sign && (s2_q.hbit || s2_q.sticky);
      f2i_pkg::RM_RMM: inc = s2_q.hbit;
      default:         inc = 1'b0;
    endcase
    s3_d.sign = s2_q.sign;
    s3_d.nan  = s2_q.nan;
    s3_d.big  = s2_q.big;
    s3_d.mag  = s2_q.big ? 64'd0 : s2_q.ip + {63'd0, inc};
    s3_d.size = s2_q.size;
    s3_d.sgn  = s2_q.sgn;
    s3_d.sat  = s2_q.sat;
  end

  // Clamp sign/magnitude into an n-bit range given by a size code.
  function automatic logic [63:0] clamp(input logic neg, input logic big,
                                        input logic [63:0] mag,
                                        input logic [1:0] size,
                                        input logic sgn);
    logic [63:0] half, umax;
    half = 64'd1 << ((7'd8 << size) - 7'd1);
    umax = (size == f2i_pkg::SIZE_64) ? '1 : ((64'd1 << (7'd8 << size)) - 64'd1);
    if (sgn) begin
      if (neg) clamp = (big || mag > half) ? -half : -mag;
      else     clamp = (big || mag > half - 64'd1) ? half - 64'd1 : mag;
    end else if (neg) begin
      clamp = '0;
    end else begin
      clamp = (big || mag > umax) ? umax : mag;
    end
  endfunction

  // Stage four: clamp or wrap, then extend narrow results.
  always_comb begin
    logic        neg;
    logic [63:0] r;
    neg = s3_q.sign && (s3_q.big || s3_q.mag != 64'd0);
    if (s3_q.nan) begin
      r = '0;
    end else if (s3_q.sat || s3_q.size == f2i_pkg::SIZE_64 ||
                 (!s3_q.sgn && s3_q.size == f2i_pkg::SIZE_32)) begin
      r = clamp(neg, s3_q.big, s3_q.mag, s3_q.size, s3_q.sgn);
    end else if (!s3_q.sgn && neg) begin
      r = '0;
    end else begin
      r = clamp(neg, s3_q.big, s3_q.mag, f2i_pkg::SIZE_64, 1'b1);
    end
    case (s3_q.size)
      f2i_pkg::SIZE_8:  res_d = {32'd0, {24{s3_q.sgn & r[7]}}, r[7:0]};
      f2i_pkg::SIZE_16: res_d = {32'd0, {16{s3_q.sgn & r[15]}}, r[15:0]};
      f2i_pkg::SIZE_32: res_d = {32'd0, r[31:0]};
      default:          res_d = r;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q  <= s1_d;
    s2_q  <= s2_d;
    s3_q  <= s3_d;
    res_q <= res_d;
  end

  assign done_o        = vld_q[3];
  assign result_bits_o = res_q;

endmodule
